// File: hw/rtl/mrl_pkg.sv
// package for the pointer-report link transmitter
// holds item types, codes, the queued command type and the check byte function
// no dependencies
package mrl_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CMD_DEPTH   = 2;
    localparam int PTR_W       = $clog2(CMD_DEPTH);
    localparam int CNT_W       = $clog2(CMD_DEPTH + 1);

    localparam logic [7:0] LINK_REQ = 8'h66;
    localparam logic [7:0] LINK_RSP = 8'h77;
    localparam logic [7:0] ACK_BYTE = 8'h88;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_BYTE = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACK     = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_REJECT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_UNLINKED = 3'b001,
        PH_IDLE     = 3'b010,
        PH_WAIT     = 3'b100
    } phase_t;

    typedef enum logic {
        CMD_SINGLE = 1'b0,
        CMD_FRAME  = 1'b1
    } cmd_op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        left_button;
        logic        right_button;
        logic        middle_button;
        logic [7:0]  move_x;
        logic [7:0]  move_y;
        logic [7:0]  wheel_move;
        logic [15:0] wait_limit;
        logic [7:0]  rx_data;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_data;
        logic        last;
        logic [1:0]  status;
        logic [15:0] remaining;
    } result_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        kind;
        logic [7:0]  tx_data;
        logic [1:0]  status;
        logic [15:0] remaining;
        frame_t      frame;
    } cmd_t;

    // parity bit and its inverse for each of the four data bytes
    function automatic logic [7:0] check_byte(input frame_t f);
        logic [7:0] c;
        logic       p;
        c = 8'h00;
        for (int i = 0; i < 4; i++)
        begin
            p = ^f[i];
            c[2*i]   = p;
            c[2*i+1] = ~p;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/mrl_item_if.sv
// input channel of the link transmitter: valid, ready and one request item
// depends on mrl_pkg
interface mrl_item_if;
    logic          valid;
    logic          ready;
    mrl_pkg::item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// File: hw/rtl/mrl_result_if.sv
// output channel of the link transmitter: valid, ready and one result item
// depends on mrl_pkg
interface mrl_result_if;
    logic            valid;
    logic            ready;
    mrl_pkg::result_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// File: hw/rtl/mouse_report_link_with_ack_retry_core.sv
// top level of the pointer-report link transmitter with acknowledge and retry
// depends on mrl_pkg, mrl_item_if, mrl_result_if, mrl_front, mrl_cmd_fifo, mrl_back
//
//  channel     | role   | payload                          | handshake
//  ------------+--------+----------------------------------+-------------
//  item_ch     | sink   | action, buttons, moves, limit, rx | valid/ready
//  result_ch   | source | kind, tx_data, last, status, rem  | valid/ready
//
// an item is taken every cycle while the two-entry command queue has room
// items that give no result only update the front end, but still wait while the queue is full
// results leave through a registered output, one per cycle while result_ch.ready is high:
// a frame gives five results, every other command one; the back end's byte counter sets this
// reset clears phase (unlinked), countdown, queue and output valid
// a stalled output holds the queue, and a full queue holds item_ch.ready low
module mouse_report_link_with_ack_retry_core (
    input  logic         clk,
    input  logic         rst_n,
    mrl_item_if.sink     item_ch,
    mrl_result_if.source result_ch
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    mrl_pkg::cmd_t push_cmd;
    mrl_pkg::cmd_t head;

    mrl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_ch  (item_ch),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mrl_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    mrl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

// File: hw/rtl/mrl_front.sv
// front end: accepts items, keeps link phase, countdown and frame store
// turns each item into at most one queued command; depends on mrl_pkg
module mrl_front (
    input  logic             clk,
    input  logic             rst_n,
    mrl_item_if.sink         item_ch,
    input  logic             full,
    output logic             push,
    output mrl_pkg::cmd_t    push_cmd
);

    mrl_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]      countdown_reg, countdown_next;
    mrl_pkg::frame_t  frame_reg, frame_next;
    logic             frame_we;
    logic             fire;
    logic [15:0]      dec;
    mrl_pkg::frame_t  built;
    mrl_pkg::item_t   it;

    assign it            = item_ch.item;
    assign item_ch.ready = !full;
    assign fire          = item_ch.valid && !full;
    assign dec           = countdown_reg - 16'd1;

    always_comb
    begin
        built    = '0;
        built[0] = {5'b00000, it.middle_button, it.right_button, it.left_button};
        built[1] = it.move_x;
        built[2] = it.move_y;
        built[3] = it.wheel_move;
        built[4] = mrl_pkg::check_byte(built);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        countdown_next     = countdown_reg;
        frame_next         = built;
        frame_we           = 1'b0;
        push               = 1'b0;
        push_cmd.op        = mrl_pkg::CMD_SINGLE;
        push_cmd.kind      = mrl_pkg::KIND_REPORT;
        push_cmd.tx_data   = 8'h00;
        push_cmd.status    = mrl_pkg::ST_ACK;
        push_cmd.remaining = 16'd0;
        push_cmd.frame     = frame_reg;
        if (fire)
        begin
            if (it.action == mrl_pkg::ACT_SEND)
            begin
                push = 1'b1;
                if (phase_reg == mrl_pkg::PH_IDLE)
                begin
                    frame_we       = 1'b1;
                    countdown_next = it.wait_limit;
                    phase_next     = mrl_pkg::PH_WAIT;
                    push_cmd.op    = mrl_pkg::CMD_FRAME;
                    push_cmd.frame = built;
                end
                else
                begin
                    push_cmd.status = mrl_pkg::ST_REJECT;
                end
            end
            else if (it.action == mrl_pkg::ACT_BYTE || it.action == mrl_pkg::ACT_TICK)
            begin
                if (phase_reg == mrl_pkg::PH_UNLINKED)
                begin
                    if (it.action == mrl_pkg::ACT_BYTE && it.rx_data == mrl_pkg::LINK_REQ)
                    begin
                        push             = 1'b1;
                        push_cmd.kind    = mrl_pkg::KIND_BYTE;
                        push_cmd.tx_data = mrl_pkg::LINK_RSP;
                        phase_next       = mrl_pkg::PH_IDLE;
                    end
                end
                else if (phase_reg == mrl_pkg::PH_WAIT)
                begin
                    countdown_next = dec;
                    if (dec == 16'd0)
                    begin
                        push            = 1'b1;
                        push_cmd.status = mrl_pkg::ST_TIMEOUT;
                        phase_next      = mrl_pkg::PH_IDLE;
                    end
                    else if (it.action == mrl_pkg::ACT_BYTE)
                    begin
                        push = 1'b1;
                        if (it.rx_data == mrl_pkg::ACK_BYTE)
                        begin
                            push_cmd.remaining = dec;
                            phase_next         = mrl_pkg::PH_IDLE;
                        end
                        else
                        begin
                            push_cmd.op = mrl_pkg::CMD_FRAME;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mrl_pkg::PH_UNLINKED;
            countdown_reg <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_reg <= frame_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && it.action == mrl_pkg::ACT_SEND && phase_reg != mrl_pkg::PH_IDLE)
        |=> $stable(phase_reg) && $stable(countdown_reg))
        else $error("rejected send changed link state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != mrl_pkg::PH_WAIT) |=> (phase_reg != mrl_pkg::PH_WAIT)
        || ($past(fire) && $past(it.action) == mrl_pkg::ACT_SEND))
        else $error("wait entered without a send");

endmodule

// File: hw/rtl/mrl_cmd_fifo.sv
// short command queue between front end and back end
// depends on mrl_pkg
module mrl_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrl_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output mrl_pkg::cmd_t head
);

    mrl_pkg::cmd_t                   mem_reg [mrl_pkg::CMD_DEPTH];
    logic [mrl_pkg::PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [mrl_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == mrl_pkg::CNT_W'(mrl_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mrl_pkg::PTR_W'(mrl_pkg::CMD_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mrl_pkg::PTR_W'(mrl_pkg::CMD_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command popped from empty queue");

endmodule

// File: hw/rtl/mrl_back.sv
// back end: plays queued commands out as result items, one per cycle unless result_ch.ready stalls the output
// frames go out byte by byte; depends on mrl_pkg
module mrl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  mrl_pkg::cmd_t    head,
    output logic             pop,
    mrl_result_if.source     result_ch
);

    logic                        out_valid_reg;
    mrl_pkg::result_t            out_item_reg, out_item_next;
    logic [mrl_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        load;
    logic                        frame_end;

    assign load      = !empty && (!out_valid_reg || result_ch.ready);
    assign frame_end = (idx_reg == mrl_pkg::IDX_W'(mrl_pkg::FRAME_BYTES - 1));

    always_comb
    begin
        out_item_next.kind      = head.kind;
        out_item_next.tx_data   = head.tx_data;
        out_item_next.last      = 1'b1;
        out_item_next.status    = head.status;
        out_item_next.remaining = head.remaining;
        idx_next                = idx_reg;
        pop                     = 1'b0;
        unique case (head.op)
            mrl_pkg::CMD_SINGLE:
            begin
                pop = load;
            end
            mrl_pkg::CMD_FRAME:
            begin
                out_item_next.kind      = mrl_pkg::KIND_BYTE;
                out_item_next.tx_data   = head.frame[idx_reg];
                out_item_next.last      = frame_end;
                out_item_next.status    = mrl_pkg::ST_ACK;
                out_item_next.remaining = 16'd0;
                if (load)
                begin
                    pop      = frame_end;
                    idx_next = frame_end ? '0 : idx_reg + 1'b1;
                end
            end
            default:
            begin
                pop = load;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.item  = out_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (!empty && head.op == mrl_pkg::CMD_FRAME))
        else $error("frame position set with no frame at queue head");

endmodule

// File: tb/tb_mouse_report_link_with_ack_retry_core.sv
// testbench for mouse_report_link_with_ack_retry_core: drives link, send, byte and tick
// requests, predicts every transmit byte and completion report, checks them in order
// depends on mrl_pkg, mrl_item_if, mrl_result_if and the core
module tb_mouse_report_link_with_ack_retry_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mrl_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         TOTAL_ITEMS    = 360;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         WATCHDOG_LIMIT = 1000;

    class link_tx_scoreboard;
        phase_t      phase;
        logic [15:0] countdown;
        logic [7:0]  frame [FRAME_BYTES];
        result_t     tx_results_due [$];
        int unsigned failures;

        function new();
            phase     = PH_UNLINKED;
            countdown = '0;
            failures  = 0;
        endfunction

        function void queue_result(kind_t kind, logic [7:0] data, logic last_flag,
                                   status_t st, logic [15:0] rem);
            result_t r;
            r.kind      = kind;
            r.tx_data   = data;
            r.last      = last_flag;
            r.status    = st;
            r.remaining = rem;
            tx_results_due.push_back(r);
        endfunction

        function void queue_frame();
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                queue_result(KIND_BYTE, frame[i], i == FRAME_BYTES - 1, ST_ACK, '0);
            end
        endfunction

        // returns 1 when the item does anything at all
        function bit note_item(item_t it);
            logic par;
            if (it.action == ACT_SEND)
            begin
                if (phase != PH_IDLE)
                begin
                    queue_result(KIND_REPORT, '0, 1'b1, ST_REJECT, '0);
                    return 1;
                end
                frame[0] = {5'b0, it.middle_button, it.right_button, it.left_button};
                frame[1] = it.move_x;
                frame[2] = it.move_y;
                frame[3] = it.wheel_move;
                frame[4] = '0;
                for (int i = 0; i < 4; i++)
                begin
                    par = ^frame[i];
                    frame[4][2*i]   = par;
                    frame[4][2*i+1] = ~par;
                end
                countdown = it.wait_limit;
                phase     = PH_WAIT;
                queue_frame();
                return 1;
            end
            if (it.action != ACT_BYTE && it.action != ACT_TICK)
                return 0;
            if (phase == PH_UNLINKED)
            begin
                if (it.action == ACT_BYTE && it.rx_data == LINK_REQ)
                begin
                    queue_result(KIND_BYTE, LINK_RSP, 1'b1, ST_ACK, '0);
                    phase = PH_IDLE;
                    return 1;
                end
                return 0;
            end
            if (phase != PH_WAIT)
                return 0;
            countdown = countdown - 16'd1;
            if (countdown == 16'd0)
            begin
                phase = PH_IDLE;
                queue_result(KIND_REPORT, '0, 1'b1, ST_TIMEOUT, '0);
                return 1;
            end
            if (it.action == ACT_TICK)
                return 1;
            if (it.rx_data == ACK_BYTE)
            begin
                phase = PH_IDLE;
                queue_result(KIND_REPORT, '0, 1'b1, ST_ACK, countdown);
                return 1;
            end
            queue_frame();
            return 1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (tx_results_due.size() == 0)
            begin
                $error("unexpected result: kind %0h tx_data %0h status %0h remaining %0h",
                       got.kind, got.tx_data, got.status, got.remaining);
                failures++;
                return;
            end
            want = tx_results_due.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("tx_data", want.tx_data, got.tx_data);
            compare_field("last", want.last, got.last);
            compare_field("status", want.status, got.status);
            compare_field("remaining", want.remaining, got.remaining);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mrl_item_if   item_ch ();
    mrl_result_if result_ch ();

    mouse_report_link_with_ack_retry_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch)
    );

    link_tx_scoreboard sb = new();

    int burst_left    = 0;
    int counted_items = 0;
    int seg_left      = 0;
    int ready_mode    = 0;
    int run_left      = 0;
    int quiet_cycles  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern, changes mode at the end of each random-length segment
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_left   = $urandom_range(20, 80);
            ready_mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (ready_mode)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= 1'($urandom_range(0, 1));
            2: result_ch.ready <= (seg_left % 4 != 0);
            default:
            begin
                result_ch.ready <= (run_left == 0);
                if (run_left == 0)
                    run_left = $urandom_range(4, 24);
                else
                    run_left--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.item);
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic item_t make_item(logic [1:0] act);
        logic [63:0] bits;
        item_t       it;
        bits      = {$urandom, $urandom};
        it        = bits[$bits(item_t)-1:0];
        it.action = act;
        return it;
    endfunction

    task automatic push_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.item  <= it;
        do @(posedge clk); while (!item_ch.ready);
        if (sb.note_item(it))
            counted_items++;
    endtask

    task automatic send_req(input logic [2:0] buttons, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] w, input logic [15:0] limit);
        item_t it;
        it               = make_item(ACT_SEND);
        it.left_button   = buttons[0];
        it.right_button  = buttons[1];
        it.middle_button = buttons[2];
        it.move_x        = x;
        it.move_y        = y;
        it.wheel_move    = w;
        it.wait_limit    = limit;
        push_item(it);
    endtask

    task automatic rx_byte(input logic [7:0] data);
        item_t it;
        it         = make_item(ACT_BYTE);
        it.rx_data = data;
        push_item(it);
    endtask

    task automatic directed_items();
        // unlinked: only the link request answers, a send is rejected
        push_item(make_item(ACT_TICK));
        rx_byte(8'h55);
        push_item(make_item(ACT_UNUSED));
        send_req(3'b111, 8'hff, 8'h00, 8'ha5, 16'd3);
        rx_byte(LINK_REQ);
        // linked and idle: all ignored
        rx_byte(LINK_REQ);
        rx_byte(ACK_BYTE);
        push_item(make_item(ACT_TICK));
        push_item(make_item(ACT_UNUSED));
        // busy reject, retry, tick, then timeout on a byte
        send_req(3'b111, 8'hff, 8'h00, 8'ha5, 16'd3);
        send_req(3'b000, 8'h01, 8'h02, 8'h03, 16'd9);
        rx_byte(8'h12);
        push_item(make_item(ACT_TICK));
        rx_byte(ACK_BYTE);
        // timeout on a tick
        send_req(3'b001, 8'h00, 8'hff, 8'h5a, 16'd1);
        push_item(make_item(ACT_TICK));
        // largest limit, acknowledged
        send_req(3'b010, 8'h80, 8'h7f, 8'h01, 16'hffff);
        push_item(make_item(ACT_UNUSED));
        rx_byte(ACK_BYTE);
        // zero limit wraps
        send_req(3'b100, 8'h33, 8'hcc, 8'hfe, 16'h0000);
        rx_byte(8'h00);
        rx_byte(ACK_BYTE);
        // link request while waiting is just another byte
        send_req(3'b101, 8'h96, 8'h69, 8'hf0, 16'd2);
        rx_byte(LINK_REQ);
        rx_byte(ACK_BYTE);
    endtask

    task automatic random_items();
        item_t it;
        int    steps;
        int    pick;
        while (counted_items < TOTAL_ITEMS)
        begin
            it   = make_item(ACT_SEND);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                it.wait_limit = '0;
            else if (pick < 4)
                it.wait_limit = 16'($urandom);
            else
                it.wait_limit = 16'($urandom_range(1, 6));
            push_item(it);
            steps = $urandom_range(0, 8);
            while (sb.phase == PH_WAIT && steps > 0)
            begin
                steps--;
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    it = make_item(ACT_BYTE);
                else if (pick < 13)
                    it = make_item(ACT_TICK);
                else if (pick < 15)
                begin
                    it         = make_item(ACT_BYTE);
                    it.rx_data = ACK_BYTE;
                end
                else if (pick < 17)
                    it = make_item(ACT_SEND);
                else if (pick < 18)
                    it = make_item(ACT_UNUSED);
                else
                begin
                    it         = make_item(ACT_BYTE);
                    it.rx_data = LINK_REQ;
                end
                push_item(it);
            end
            if (sb.phase == PH_WAIT)
                rx_byte(ACK_BYTE);
            if ($urandom_range(0, 3) == 0)
                push_item(make_item(2'($urandom_range(1, 3))));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.item    = '0;
        result_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        random_items();
        item_ch.valid <= 1'b0;
        while (sb.tx_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
